[hw/rtl/olist_pkg.sv]
package olist_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_WALK   = 9'b000000100,
    S_APP    = 9'b000001000,
    S_INS1   = 9'b000010000,
    S_INS2   = 9'b000100000,
    S_DEL1   = 9'b001000000,
    S_DEL2   = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_e;

  // per-field write enables of the node memory
  typedef struct packed {
    logic value;
    logic next;
    logic prev;
  } wr_en_t;

endpackage

[hw/rtl/olist_node_mem.sv]
module olist_node_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned IdxW  = 5
) (
  input  logic                        clk_i,
  input  olist_pkg::wr_en_t           we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [olist_pkg::ValueW-1:0] wvalue_i,
  input  logic [IdxW-1:0]             wnext_i,
  input  logic [IdxW-1:0]             wprev_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [olist_pkg::ValueW-1:0] rvalue_o,
  output logic [IdxW-1:0]             rnext_o,
  output logic [IdxW-1:0]             rprev_o
);

  logic [olist_pkg::ValueW-1:0] value_mem [Depth];
  logic [IdxW-1:0]              next_mem  [Depth];
  logic [IdxW-1:0]              prev_mem  [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i.value) begin
      value_mem[waddr_i] <= wvalue_i;
    end
    if (we_i.next) begin
      next_mem[waddr_i] <= wnext_i;
    end
    if (we_i.prev) begin
      prev_mem[waddr_i] <= wprev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rvalue_o <= value_mem[raddr_i];
      rnext_o  <= next_mem[raddr_i];
      rprev_o  <= prev_mem[raddr_i];
    end
  end

endmodule

[hw/rtl/ordered_list_engine.sv]
// Ordered list engine: a doubly linked list of up to CAPACITY signed 32-bit words held in
// one node memory (value, next and prev link per node) with head, tail and a free map in
// registers. One request is taken at a time; a new request is accepted as soon as the
// previous one has put its last result into the output register. Append writes a free
// node on acceptance, links it behind the tail in S_APP and gives its result in S_EMIT.
// Insert-after and delete walk the list through the single read port of the node memory,
// one node per cycle from the head, then update the links in S_INS1 and S_INS2 or in
// S_DEL1 and S_DEL2 and give the result in S_EMIT; a missing key ends the walk after at
// most CAPACITY nodes. Readout delivers one word per cycle, head to tail, once the walk
// has started; a held output register stalls the walk.
// status is ok, not found, store full (no free node) or empty (readout of an empty list).
// No clearing pass is needed after reset.
module ordered_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // match_key [31:0], new_value [63:32]
  input  logic [1:0]  s_axis_tuser,   // req_type [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // item_value [31:0]
  output logic [1:0]  m_axis_tuser,   // status [1:0]
  output logic        m_axis_tlast    // last_item
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NoneIdx = IW'(CAPACITY);
  localparam logic [AW-1:0] LastStep = AW'(CAPACITY - 1);
  localparam logic [CAPACITY-1:0] AllFree = {CAPACITY{1'b1}};

  olist_pkg::state_e state_q, state_d;
  olist_pkg::req_e   req_q, req_d;
  olist_pkg::status_e res_q, res_d;
  logic [31:0]         key_q, key_d, val_q, val_d;
  logic [IW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [IW-1:0]       ptr_q, ptr_d, new_q, new_d;
  logic [IW-1:0]       t_q, t_d, x_q, x_d, p_q, p_d;
  logic [AW-1:0]       step_q, step_d;
  logic [CAPACITY-1:0] free_q, free_d;

  logic                out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [1:0]          out_status_q, out_status_d;
  logic [31:0]         out_value_q, out_value_d;
  logic                out_free;

  olist_pkg::wr_en_t   we;
  logic [AW-1:0]       waddr, raddr;
  logic [31:0]         wvalue;
  logic [IW-1:0]       wnext, wprev;
  logic                ren;
  logic [31:0]         rvalue;
  logic [IW-1:0]       rnext, rprev;

  logic                has_free;
  logic [IW-1:0]       first_free;
  logic                accept;
  olist_pkg::req_e     in_req;

  olist_node_mem #(
    .Depth(CAPACITY),
    .AddrW(AW),
    .IdxW (IW)
  ) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wvalue_i(wvalue),
    .wnext_i (wnext),
    .wprev_i (wprev),
    .re_i    (ren),
    .raddr_i (raddr),
    .rvalue_o(rvalue),
    .rnext_o (rnext),
    .rprev_o (rprev)
  );

  // lowest free node
  always_comb begin
    first_free = NoneIdx;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        first_free = IW'(i);
      end
    end
  end
  assign has_free = |free_q;

  assign s_axis_tready = (state_q == olist_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_req        = olist_pkg::req_e'(s_axis_tuser);
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    res_d   = res_q;
    key_d   = key_q;
    val_d   = val_q;
    head_d  = head_q;
    tail_d  = tail_q;
    ptr_d   = ptr_q;
    new_d   = new_q;
    t_d     = t_q;
    x_d     = x_q;
    p_d     = p_q;
    step_d  = step_q;
    free_d  = free_q;

    we     = '0;
    waddr  = new_q[AW-1:0];
    wvalue = val_q;
    wnext  = NoneIdx;
    wprev  = NoneIdx;
    ren    = 1'b0;
    raddr  = head_q[AW-1:0];

    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      olist_pkg::S_IDLE: begin
        if (accept) begin
          req_d  = in_req;
          key_d  = s_axis_tdata[31:0];
          val_d  = s_axis_tdata[63:32];
          step_d = '0;
          ptr_d  = head_q;
          unique case (in_req) inside
            olist_pkg::REQ_APPEND: begin
              if (!has_free) begin
                res_d   = olist_pkg::ST_FULL;
                state_d = olist_pkg::S_EMIT;
              end else begin
                we     = '{value: 1'b1, next: 1'b1, prev: 1'b1};
                waddr  = first_free[AW-1:0];
                wvalue = s_axis_tdata[63:32];
                wnext  = NoneIdx;
                wprev  = tail_q;
                free_d[first_free[AW-1:0]] = 1'b0;
                new_d   = first_free;
                state_d = olist_pkg::S_APP;
              end
            end
            olist_pkg::REQ_INSERT, olist_pkg::REQ_DELETE: begin
              if (head_q == NoneIdx) begin
                res_d   = olist_pkg::ST_NOT_FOUND;
                state_d = olist_pkg::S_EMIT;
              end else begin
                ren     = 1'b1;
                state_d = olist_pkg::S_SEARCH;
              end
            end
            default: begin
              if (head_q == NoneIdx) begin
                res_d   = olist_pkg::ST_EMPTY;
                state_d = olist_pkg::S_EMIT;
              end else begin
                ren     = 1'b1;
                state_d = olist_pkg::S_WALK;
              end
            end
          endcase
        end
      end

      olist_pkg::S_SEARCH: begin
        if (rvalue == key_q) begin
          t_d = ptr_q;
          x_d = rnext;
          p_d = rprev;
          if (req_q == olist_pkg::REQ_DELETE) begin
            state_d = olist_pkg::S_DEL1;
          end else if (!has_free) begin
            res_d   = olist_pkg::ST_FULL;
            state_d = olist_pkg::S_EMIT;
          end else begin
            we     = '{value: 1'b1, next: 1'b1, prev: 1'b1};
            waddr  = first_free[AW-1:0];
            wvalue = val_q;
            wnext  = rnext;
            wprev  = ptr_q;
            free_d[first_free[AW-1:0]] = 1'b0;
            new_d   = first_free;
            state_d = olist_pkg::S_INS1;
          end
        end else if (rnext == NoneIdx || step_q == LastStep) begin
          res_d   = olist_pkg::ST_NOT_FOUND;
          state_d = olist_pkg::S_EMIT;
        end else begin
          ren    = 1'b1;
          raddr  = rnext[AW-1:0];
          ptr_d  = rnext;
          step_d = step_q + 1'b1;
        end
      end

      olist_pkg::S_WALK: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = olist_pkg::ST_OK;
          out_value_d  = rvalue;
          out_last_d   = (rnext == NoneIdx) || (step_q == LastStep);
          if ((rnext == NoneIdx) || (step_q == LastStep)) begin
            state_d = olist_pkg::S_IDLE;
          end else begin
            ren    = 1'b1;
            raddr  = rnext[AW-1:0];
            step_d = step_q + 1'b1;
          end
        end
      end

      olist_pkg::S_APP: begin
        if (tail_q != NoneIdx) begin
          we.next = 1'b1;
          waddr   = tail_q[AW-1:0];
          wnext   = new_q;
        end else begin
          head_d = new_q;
        end
        tail_d  = new_q;
        res_d   = olist_pkg::ST_OK;
        state_d = olist_pkg::S_EMIT;
      end

      olist_pkg::S_INS1: begin
        we.next = 1'b1;
        waddr   = t_q[AW-1:0];
        wnext   = new_q;
        state_d = olist_pkg::S_INS2;
      end

      olist_pkg::S_INS2: begin
        if (x_q != NoneIdx) begin
          we.prev = 1'b1;
          waddr   = x_q[AW-1:0];
          wprev   = new_q;
        end else begin
          tail_d = new_q;
        end
        res_d   = olist_pkg::ST_OK;
        state_d = olist_pkg::S_EMIT;
      end

      olist_pkg::S_DEL1: begin
        if (p_q != NoneIdx) begin
          we.next = 1'b1;
          waddr   = p_q[AW-1:0];
          wnext   = x_q;
        end else begin
          head_d = x_q;
        end
        free_d[t_q[AW-1:0]] = 1'b1;
        state_d = olist_pkg::S_DEL2;
      end

      olist_pkg::S_DEL2: begin
        if (x_q != NoneIdx) begin
          we.prev = 1'b1;
          waddr   = x_q[AW-1:0];
          wprev   = p_q;
        end else begin
          tail_d = p_q;
        end
        res_d   = olist_pkg::ST_OK;
        state_d = olist_pkg::S_EMIT;
      end

      olist_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          state_d      = olist_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = olist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olist_pkg::S_IDLE;
      head_q      <= NoneIdx;
      tail_q      <= NoneIdx;
      free_q      <= AllFree;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    res_q        <= res_d;
    key_q        <= key_d;
    val_q        <= val_d;
    ptr_q        <= ptr_d;
    new_q        <= new_d;
    t_q          <= t_d;
    x_q          <= x_d;
    p_q          <= p_d;
    step_q       <= step_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP         = 16;
  localparam logic [4:0]  NO_NODE     = 5'(CAP);
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_LEN    = 300;

  typedef struct packed {
    olist_pkg::status_e st;
    logic [31:0]        val;
    logic               last;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // match_key [31:0], new_value [63:32]
  logic [1:0]  s_axis_tuser = '0;   // req_type [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // item_value [31:0]
  logic [1:0]  m_axis_tuser;        // status [1:0]
  logic        m_axis_tlast;        // last_item

  // mirror of the linked list, indexed by 5-bit node numbers
  logic [31:0]    list_val  [2*CAP];
  logic [4:0]     list_next [2*CAP];
  logic [4:0]     list_prev [2*CAP];
  logic [CAP-1:0] list_free = '1;
  logic [4:0]     list_head = NO_NODE;
  logic [4:0]     list_tail = NO_NODE;

  word_t       due_q[$];
  int unsigned snd_idle;
  int unsigned rcv_idle;
  int unsigned mismatches;
  int unsigned cycles;
  logic        rcv_hold = 1'b0;
  event        hold_go;

  ordered_list_engine #(
    .CAPACITY(CAP)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [4:0] find_first(logic [31:0] key);
    logic [4:0] t;
    t = list_head;
    for (int steps = 0; steps < CAP && t < CAP; steps++) begin
      if (list_val[t] == key) return t;
      t = list_next[t];
    end
    return NO_NODE;
  endfunction

  function automatic logic [4:0] take_free();
    for (int i = 0; i < CAP; i++) begin
      if (list_free[i]) begin
        list_free[i] = 1'b0;
        return 5'(i);
      end
    end
    return NO_NODE;
  endfunction

  function automatic void push_word(olist_pkg::status_e st, logic [31:0] val, logic last);
    word_t w;
    w.st   = st;
    w.val  = val;
    w.last = last;
    due_q = {due_q, w};
  endfunction

  // updates the mirror and queues the words a request must produce
  function automatic void apply_request(olist_pkg::req_e req, logic [31:0] key,
                                        logic [31:0] val);
    logic [4:0] t;
    logic [4:0] n;
    logic [4:0] p;
    logic [4:0] x;
    int         k;
    case (req)
      olist_pkg::REQ_APPEND: begin
        n = take_free();
        if (n == NO_NODE) begin
          push_word(olist_pkg::ST_FULL, '0, 1'b1);
        end else begin
          list_val[n]  = val;
          list_next[n] = NO_NODE;
          list_prev[n] = list_tail;
          if (list_tail < CAP) list_next[list_tail] = n;
          else list_head = n;
          list_tail = n;
          push_word(olist_pkg::ST_OK, '0, 1'b1);
        end
      end
      olist_pkg::REQ_INSERT: begin
        t = find_first(key);
        if (t == NO_NODE) begin
          push_word(olist_pkg::ST_NOT_FOUND, '0, 1'b1);
        end else begin
          n = take_free();
          if (n == NO_NODE) begin
            push_word(olist_pkg::ST_FULL, '0, 1'b1);
          end else begin
            list_val[n]  = val;
            list_next[n] = list_next[t];
            list_prev[n] = t;
            if (list_next[t] < CAP) list_prev[list_next[t]] = n;
            else list_tail = n;
            list_next[t] = n;
            push_word(olist_pkg::ST_OK, '0, 1'b1);
          end
        end
      end
      olist_pkg::REQ_DELETE: begin
        t = find_first(key);
        if (t == NO_NODE) begin
          push_word(olist_pkg::ST_NOT_FOUND, '0, 1'b1);
        end else begin
          p = list_prev[t];
          x = list_next[t];
          if (p < CAP) list_next[p] = x;
          else list_head = x;
          if (x < CAP) list_prev[x] = p;
          else list_tail = p;
          list_next[t] = NO_NODE;
          list_prev[t] = NO_NODE;
          list_free[t[3:0]] = 1'b1;
          push_word(olist_pkg::ST_OK, '0, 1'b1);
        end
      end
      default: begin
        if (list_head == NO_NODE) begin
          push_word(olist_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          t = list_head;
          k = 0;
          while (k < CAP && t < CAP) begin
            x = list_next[t];
            push_word(olist_pkg::ST_OK, list_val[t], (x >= CAP) || (k == CAP - 1));
            k++;
            t = x;
          end
        end
      end
    endcase
  endfunction

  task automatic send_word(olist_pkg::req_e req, logic [31:0] key, logic [31:0] val);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, key};
    s_axis_tuser  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_request(req, key, val);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned list_count();
    return CAP - $countones(list_free);
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(5))
      0, 1: begin
        v = 32'($urandom_range(7));
        if ($urandom_range(1)) v = -v;
      end
      2: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [31:0] stored_value();
    logic [4:0] t;
    t = list_head;
    repeat ($urandom_range(list_count() - 1)) t = list_next[t];
    return list_val[t];
  endfunction

  task automatic test_directed();
    send_word(olist_pkg::REQ_READ, 32'd0, 32'd0);
    send_word(olist_pkg::REQ_DELETE, 32'd7, 32'd0);
    send_word(olist_pkg::REQ_INSERT, 32'd7, 32'd1);
    send_word(olist_pkg::REQ_APPEND, 32'd0, 32'h8000_0000);
    send_word(olist_pkg::REQ_APPEND, 32'd0, 32'h7fff_ffff);
    send_word(olist_pkg::REQ_APPEND, 32'd0, 32'h0000_0000);
    send_word(olist_pkg::REQ_APPEND, 32'd0, 32'hffff_ffff);
    send_word(olist_pkg::REQ_READ, 32'd0, 32'd0);
    send_word(olist_pkg::REQ_INSERT, 32'h7fff_ffff, 32'h1234_5678);
    send_word(olist_pkg::REQ_INSERT, 32'hffff_ffff, 32'd5);
    send_word(olist_pkg::REQ_APPEND, 32'hffff_ffff, 32'd0);
    send_word(olist_pkg::REQ_INSERT, 32'd0, 32'd99);
    send_word(olist_pkg::REQ_READ, 32'd0, 32'd0);
    send_word(olist_pkg::REQ_DELETE, 32'h8000_0000, 32'd0);
    send_word(olist_pkg::REQ_DELETE, 32'd5, 32'd0);
    send_word(olist_pkg::REQ_DELETE, 32'd0, 32'd0);
    send_word(olist_pkg::REQ_DELETE, 32'h55aa_55aa, 32'd0);
    send_word(olist_pkg::REQ_READ, 32'h8000_0000, 32'h7fff_ffff);
    pause_until_drained();
  endtask

  // receiver stalls while the store fills up, then everything is removed
  task automatic test_full_store_under_hold();
    logic [31:0] miss;
    -> hold_go;
    while (list_free != '0) send_word(olist_pkg::REQ_APPEND, random_value(), random_value());
    send_word(olist_pkg::REQ_APPEND, $urandom(), $urandom());
    send_word(olist_pkg::REQ_INSERT, list_val[list_tail], $urandom());
    miss = $urandom();
    while (find_first(miss) != NO_NODE) miss = $urandom();
    send_word(olist_pkg::REQ_INSERT, miss, $urandom());
    send_word(olist_pkg::REQ_READ, $urandom(), $urandom());
    pause_until_drained();
    while (list_head != NO_NODE) begin
      send_word(olist_pkg::REQ_DELETE, list_val[list_head], $urandom());
    end
    send_word(olist_pkg::REQ_READ, $urandom(), $urandom());
    pause_until_drained();
  endtask

  task automatic test_random(int unsigned n);
    int unsigned     r;
    olist_pkg::req_e req;
    logic [31:0]     key;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (list_count() >= CAP - 2 && r < 50) req = olist_pkg::REQ_DELETE;
      else if (r < 35) req = olist_pkg::REQ_APPEND;
      else if (r < 55) req = olist_pkg::REQ_INSERT;
      else if (r < 82) req = olist_pkg::REQ_DELETE;
      else req = olist_pkg::REQ_READ;
      if (list_count() > 0 && $urandom_range(9) < 7) key = stored_value();
      else key = random_value();
      send_word(req, key, random_value());
    end
    pause_until_drained();
  endtask

  task automatic check_word();
    word_t w;
    if (due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected word: status %0d value %h last %b",
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end
    end else begin
      w = due_q.pop_front();
      if (m_axis_tuser !== w.st || m_axis_tdata !== w.val || m_axis_tlast !== w.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected status %0d value %h last %b, %s %0d value %h last %b",
                   w.st, w.val, w.last, "got status",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_word();
      m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    forever begin
      @(hold_go);
      rcv_hold <= 1'b1;
      repeat (HOLD_LEN) @(posedge clk_i);
      rcv_hold <= 1'b0;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    mismatches = 0;
    snd_idle   = 29;
    rcv_idle   = 86;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(100);
    snd_idle = 86;
    rcv_idle = 29;
    test_random(100);
    snd_idle = 0;
    rcv_idle = 0;
    test_full_store_under_hold();
    test_random(100);
    repeat (2 * CAP + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
